[rtl/admission_limiter_token_bucket_unit_macros.svh]
// ----------------------------------------------------------------------------
// Admission limiter assertion macros
// Shorthand for the concurrent assertions, clocked on clk and held off by rst.
// ----------------------------------------------------------------------------
`ifndef ADMISSION_LIMITER_TOKEN_BUCKET_UNIT_MACROS_SVH
`define ADMISSION_LIMITER_TOKEN_BUCKET_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ALTB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ALTB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/altb_pkg.sv]
// ----------------------------------------------------------------------------
// Admission limiter package
// Shared widths, codes, the bucket record and the bucket arithmetic.
// ----------------------------------------------------------------------------
package altb_pkg;

  localparam int ENDPOINT_COUNT_DEF = 64;
  localparam int COUNT_WIDTH_DEF    = 16;

  localparam int LIMIT_W    = 16;
  localparam int MILLI_W    = 26;
  localparam int TIME_W     = 48;
  localparam int EP_IDX_W   = 6;
  localparam int CAUSE_W    = 3;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  localparam logic [9:0] MILLI = 10'd1000;

  typedef enum logic {
    OP_ACQUIRE,
    OP_RELEASE
  } op_t;

  typedef enum logic [CAUSE_W-1:0] {
    CAUSE_NONE,
    CAUSE_GLOBAL_CONC,
    CAUSE_SERVICE_CONC,
    CAUSE_ENDPOINT_CONC,
    CAUSE_GLOBAL_RATE,
    CAUSE_SERVICE_RATE,
    CAUSE_ENDPOINT_RATE
  } cause_t;

  typedef enum logic [2:0] {
    REG_GLOBAL_CONC,
    REG_SERVICE_CONC,
    REG_ENDPOINT_CONC,
    REG_GLOBAL_RATE,
    REG_SERVICE_RATE,
    REG_ENDPOINT_RATE
  } reg_idx_t;

  typedef struct packed {
    logic [MILLI_W-1:0] milli;
    logic [TIME_W-1:0]  last_ms;
    logic [LIMIT_W-1:0] capacity;
    logic               valid;
  } bucket_t;

  // Reload or refill a bucket ahead of taking a token; no token is taken here.
  function automatic bucket_t bucket_refill(bucket_t b, logic [LIMIT_W-1:0] rate,
                                            logic [TIME_W-1:0] now);
    bucket_t             r;
    logic [TIME_W-1:0]   el_full;
    logic [9:0]          el;
    logic [MILLI_W:0]    sum;
    logic [MILLI_W-1:0]  cap_m;
    r       = b;
    el_full = now - b.last_ms;
    el      = (el_full > TIME_W'(MILLI)) ? MILLI : el_full[9:0];
    sum     = (MILLI_W+1)'(b.milli) + (MILLI_W+1)'(MILLI_W'(el) * MILLI_W'(rate));
    cap_m   = MILLI_W'(b.capacity) * MILLI_W'(MILLI);
    if (!b.valid || (b.capacity != rate)) begin
      r.capacity = rate;
      r.milli    = MILLI_W'(rate) * MILLI_W'(MILLI);
      r.last_ms  = now;
      r.valid    = 1'b1;
    end else if (now > b.last_ms) begin
      r.milli   = (sum > (MILLI_W+1)'(cap_m)) ? cap_m : sum[MILLI_W-1:0];
      r.last_ms = now;
    end
    return r;
  endfunction

  // Return one token, capped at the capacity; an empty-capacity bucket is left alone.
  function automatic bucket_t bucket_give(bucket_t b);
    bucket_t            r;
    logic [MILLI_W:0]   sum;
    logic [MILLI_W-1:0] cap_m;
    r     = b;
    sum   = (MILLI_W+1)'(b.milli) + (MILLI_W+1)'(MILLI);
    cap_m = MILLI_W'(b.capacity) * MILLI_W'(MILLI);
    if (b.capacity != '0) begin
      r.milli = (sum > (MILLI_W+1)'(cap_m)) ? cap_m : sum[MILLI_W-1:0];
    end
    return r;
  endfunction

  function automatic logic bucket_has_token(bucket_t b);
    return b.milli >= MILLI_W'(MILLI);
  endfunction

endpackage

[rtl/altb_if.sv]
// ----------------------------------------------------------------------------
// Admission limiter channels
// Request and response channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface altb_req_if import altb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                operation;
  logic [EP_IDX_W-1:0] endpoint_index;
  logic [TIME_W-1:0]   now_ms;
  logic                global_held;

  modport source (output valid, operation, endpoint_index, now_ms, global_held,
                  input ready);
  modport sink   (input valid, operation, endpoint_index, now_ms, global_held,
                  output ready);
endinterface

interface altb_rsp_if import altb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               granted;
  logic [CAUSE_W-1:0] deny_cause;
  logic               global_taken;

  modport source (output valid, granted, deny_cause, global_taken, input ready);
  modport sink   (input valid, granted, deny_cause, global_taken, output ready);
endinterface

[rtl/admission_limiter_token_bucket_unit.sv]
// ----------------------------------------------------------------------------
// Admission limiter with token buckets
// Concurrency limits and token-bucket rate limits for request admission.
// ----------------------------------------------------------------------------
// Usage: each request transaction on req is either an acquire or a release.
// An acquire is checked against the global, service and endpoint concurrency
// limits and then against the three token buckets; one response transaction
// on rsp reports whether it was granted and, if not, which check denied it.
// A release hands back a slot and is always granted.
// Limits are written through the APB port; the user must write them only while
// the block is idle, as the block itself does not enforce it. The accepting
// edge loads the stage register together with the endpoint memory entry;
// when the stage advances, all the checks and updates are done and the
// response register is loaded. Throughput is one transaction per cycle while
// the receiver takes responses; a write of the endpoint memory is forwarded
// to a read of the same endpoint in the same cycle.
// After reset the endpoint memory is cleared, one entry per cycle, and
// req.ready stays low meanwhile.
// When the receiver stalls, the response stays in its register and the
// stage holds one more item; further requests are then refused.
// ----------------------------------------------------------------------------
`include "admission_limiter_token_bucket_unit_macros.svh"

module admission_limiter_token_bucket_unit import altb_pkg::*; #(
  parameter int ENDPOINT_COUNT = ENDPOINT_COUNT_DEF,
  parameter int COUNT_WIDTH    = COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  altb_req_if.sink              req,
  altb_rsp_if.source            rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int EA    = (ENDPOINT_COUNT > 1) ? $clog2(ENDPOINT_COUNT) : 1;
  localparam int CMP_W = 32;
  localparam int REM_W = 19;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  // Configuration registers.
  logic [LIMIT_W-1:0] global_conc_limit, service_conc_limit, endpoint_conc_limit;
  logic [LIMIT_W-1:0] global_rate_limit, service_rate_limit, endpoint_rate_limit;
  logic               cfg_write;
  reg_idx_t           cfg_idx;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_idx   = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      global_conc_limit   <= '0;
      service_conc_limit  <= '0;
      endpoint_conc_limit <= '0;
      global_rate_limit   <= '0;
      service_rate_limit  <= '0;
      endpoint_rate_limit <= '0;
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_GLOBAL_CONC:   global_conc_limit   <= pwdata[LIMIT_W-1:0];
        REG_SERVICE_CONC:  service_conc_limit  <= pwdata[LIMIT_W-1:0];
        REG_ENDPOINT_CONC: endpoint_conc_limit <= pwdata[LIMIT_W-1:0];
        REG_GLOBAL_RATE:   global_rate_limit   <= pwdata[LIMIT_W-1:0];
        REG_SERVICE_RATE:  service_rate_limit  <= pwdata[LIMIT_W-1:0];
        REG_ENDPOINT_RATE: endpoint_rate_limit <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_GLOBAL_CONC:   prdata = APB_DATA_W'(global_conc_limit);
      REG_SERVICE_CONC:  prdata = APB_DATA_W'(service_conc_limit);
      REG_ENDPOINT_CONC: prdata = APB_DATA_W'(endpoint_conc_limit);
      REG_GLOBAL_RATE:   prdata = APB_DATA_W'(global_rate_limit);
      REG_SERVICE_RATE:  prdata = APB_DATA_W'(service_rate_limit);
      REG_ENDPOINT_RATE: prdata = APB_DATA_W'(endpoint_rate_limit);
      default:           prdata = '0;
    endcase
  end

  // Clearing pass over the endpoint memory after reset.
  logic          clr_busy;
  logic [EA-1:0] clr_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_idx  <= '0;
    end else if (clr_busy) begin
      if (clr_idx == EA'(ENDPOINT_COUNT - 1)) begin
        clr_busy <= 1'b0;
      end
      clr_idx <= clr_idx + EA'(1);
    end
  end

  // Stage and handshake control.
  logic s_valid, o_valid, advance, in_accept;

  assign advance   = s_valid && (!o_valid || rsp.ready);
  assign req.ready = !clr_busy && (!s_valid || advance);
  assign in_accept = req.valid && req.ready;

  // Endpoint index reduced modulo the endpoint count by restoring subtraction.
  logic [REM_W-1:0] ep_rem;
  logic [EA-1:0]    in_ep;

  always_comb begin
    ep_rem = REM_W'(req.endpoint_index);
    for (int k = EP_IDX_W - 1; k >= 0; k--) begin
      if (ep_rem >= (REM_W'(ENDPOINT_COUNT) << k)) begin
        ep_rem = ep_rem - (REM_W'(ENDPOINT_COUNT) << k);
      end
    end
    in_ep = ep_rem[EA-1:0];
  end

  // Stage register, loaded with the request and the endpoint entry.
  logic                   s_op, s_held;
  logic [EA-1:0]          s_ep;
  logic [TIME_W-1:0]      s_now;
  logic [COUNT_WIDTH-1:0] s_eact;
  bucket_t                s_ebkt;

  // Global and service state.
  logic [COUNT_WIDTH-1:0] global_active, service_active;
  bucket_t                gbkt, sbkt;

  // Next values from the checks.
  logic [COUNT_WIDTH-1:0] global_active_next, service_active_next, eact_next;
  bucket_t                gbkt_next, sbkt_next, ebkt_next;
  cause_t                 cause;
  logic                   acq_granted, gcount;

  // Endpoint memories.
  logic [COUNT_WIDTH-1:0] ep_act_mem [ENDPOINT_COUNT];
  bucket_t                ep_bkt_mem [ENDPOINT_COUNT];

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      ep_act_mem[clr_idx] <= '0;
      ep_bkt_mem[clr_idx] <= '0;
    end else if (advance) begin
      ep_act_mem[s_ep] <= eact_next;
      ep_bkt_mem[s_ep] <= ebkt_next;
    end
    if (in_accept) begin
      if (advance && (s_ep == in_ep)) begin
        s_eact <= eact_next;
        s_ebkt <= ebkt_next;
      end else begin
        s_eact <= ep_act_mem[in_ep];
        s_ebkt <= ep_bkt_mem[in_ep];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_accept) begin
      s_valid <= 1'b1;
    end else if (advance) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s_op   <= req.operation;
      s_ep   <= in_ep;
      s_now  <= req.now_ms;
      s_held <= req.global_held;
    end
  end

  function automatic logic [COUNT_WIDTH-1:0] cnt_inc(logic [COUNT_WIDTH-1:0] v);
    return (v == CNT_MAX) ? v : v + COUNT_WIDTH'(1);
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] cnt_dec(logic [COUNT_WIDTH-1:0] v);
    return (v == '0) ? v : v - COUNT_WIDTH'(1);
  endfunction

  // Checks and updates for the item in the stage.
  logic    c_g, c_s, c_e, conc_ok, g_ok, s_ok, e_ok;
  bucket_t g_ref, s_ref, e_ref;

  always_comb begin
    gcount  = (global_conc_limit != '0);
    c_g     = gcount && (CMP_W'(global_active) >= CMP_W'(global_conc_limit));
    c_s     = (service_conc_limit != '0) &&
              (CMP_W'(service_active) >= CMP_W'(service_conc_limit));
    c_e     = (endpoint_conc_limit != '0) &&
              (CMP_W'(s_eact) >= CMP_W'(endpoint_conc_limit));
    conc_ok = !c_g && !c_s && !c_e;

    g_ref = bucket_refill(gbkt, global_rate_limit, s_now);
    s_ref = bucket_refill(sbkt, service_rate_limit, s_now);
    e_ref = bucket_refill(s_ebkt, endpoint_rate_limit, s_now);
    g_ok  = (global_rate_limit == '0) || bucket_has_token(g_ref);
    s_ok  = (service_rate_limit == '0) || bucket_has_token(s_ref);
    e_ok  = (endpoint_rate_limit == '0) || bucket_has_token(e_ref);

    if (c_g)        cause = CAUSE_GLOBAL_CONC;
    else if (c_s)   cause = CAUSE_SERVICE_CONC;
    else if (c_e)   cause = CAUSE_ENDPOINT_CONC;
    else if (!g_ok) cause = CAUSE_GLOBAL_RATE;
    else if (!s_ok) cause = CAUSE_SERVICE_RATE;
    else if (!e_ok) cause = CAUSE_ENDPOINT_RATE;
    else            cause = CAUSE_NONE;
    acq_granted = (cause == CAUSE_NONE);

    global_active_next  = global_active;
    service_active_next = service_active;
    eact_next           = s_eact;
    gbkt_next           = gbkt;
    sbkt_next           = sbkt;
    ebkt_next           = s_ebkt;

    if (s_op == OP_RELEASE) begin
      service_active_next = cnt_dec(service_active);
      eact_next           = cnt_dec(s_eact);
      if (s_held) begin
        global_active_next = cnt_dec(global_active);
      end
    end else begin
      // A denied item counts up and then back down, which is not neutral
      // when the counter sits at its saturation value.
      if (!c_g && gcount) begin
        global_active_next = acq_granted ? cnt_inc(global_active)
                                         : cnt_dec(cnt_inc(global_active));
      end
      if (conc_ok) begin
        service_active_next = acq_granted ? cnt_inc(service_active)
                                          : cnt_dec(cnt_inc(service_active));
        eact_next           = acq_granted ? cnt_inc(s_eact)
                                          : cnt_dec(cnt_inc(s_eact));
        // A token is kept only when the whole item is granted; a later
        // failure gives back what an earlier bucket took.
        if (global_rate_limit != '0) begin
          gbkt_next = g_ref;
          if (acq_granted) gbkt_next.milli = g_ref.milli - MILLI_W'(MILLI);
        end
        if (g_ok) begin
          if (service_rate_limit != '0) begin
            sbkt_next = s_ref;
            if (acq_granted) sbkt_next.milli = s_ref.milli - MILLI_W'(MILLI);
          end else if (cause == CAUSE_ENDPOINT_RATE) begin
            sbkt_next = bucket_give(sbkt);
          end
        end
        if (g_ok && s_ok && (endpoint_rate_limit != '0)) begin
          ebkt_next = e_ref;
          if (acq_granted) ebkt_next.milli = e_ref.milli - MILLI_W'(MILLI);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      global_active  <= '0;
      service_active <= '0;
      gbkt           <= '0;
      sbkt           <= '0;
    end else if (advance) begin
      global_active  <= global_active_next;
      service_active <= service_active_next;
      gbkt           <= gbkt_next;
      sbkt           <= sbkt_next;
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (advance) begin
      o_valid <= 1'b1;
    end else if (rsp.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (s_op == OP_RELEASE) begin
        rsp.granted      <= 1'b1;
        rsp.deny_cause   <= CAUSE_NONE;
        rsp.global_taken <= 1'b0;
      end else begin
        rsp.granted      <= acq_granted;
        rsp.deny_cause   <= cause;
        rsp.global_taken <= acq_granted && gcount;
      end
    end
  end

  assign rsp.valid = o_valid;

  `ALTB_ASSERT_NOW(a_no_accept_in_clear, clr_busy, !req.ready, "request accepted during clear")
  `ALTB_ASSERT_NOW(a_deny_has_cause, rsp.valid && !rsp.granted, (rsp.deny_cause != CAUSE_NONE) && !rsp.global_taken, "denied response without cause")
  `ALTB_ASSERT_NEXT(a_deny_keeps_service, advance && (s_op == OP_ACQUIRE) && !acq_granted && (service_active != CNT_MAX), service_active == $past(service_active), "denied acquire changed service count")
  `ALTB_ASSERT_NEXT(a_stall_holds_stage, s_valid && !advance, s_valid, "stage item lost during stall")

endmodule

[tb/sv/admission_limiter_token_bucket_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Admission limiter testbench
// Drives acquire and release transactions under a range of limit settings,
// predicts each response from its own model of the counters and token
// buckets, and compares every response field by field.
// ----------------------------------------------------------------------------
module admission_limiter_token_bucket_unit_tb;
  import altb_pkg::*;

  localparam int EP_N      = 64;
  localparam int CNT_TOP   = 65535;
  localparam int WDOG_MAX  = 20000;
  localparam int HOLD_LONG = 300;

  // Admission model: counters, buckets and limits, plus the queue of
  // responses still to come.
  class admission_board;
    typedef struct {
      bit                   granted;
      cause_t               cause;
      bit                   taken;
    } verdict_t;

    int unsigned       lim [6];
    int unsigned       g_act, s_act;
    int unsigned       e_act [EP_N];
    // Buckets: 0 global, 1 service, 2 onwards one per endpoint.
    longint unsigned   b_milli [EP_N+2];
    longint unsigned   b_last  [EP_N+2];
    int unsigned       b_cap   [EP_N+2];
    bit                b_valid [EP_N+2];
    verdict_t          awaited [$];
    // Slots granted so far, kept so that releases can be well formed.
    int unsigned       held_ep [$];
    bit                held_g  [$];
    int                errors;
    int                grants, denials, releases;
    int                cause_seen [7];

    function new();
      foreach (lim[i]) lim[i] = 0;
      g_act = 0; s_act = 0;
      foreach (e_act[i]) e_act[i] = 0;
      foreach (b_milli[i]) begin
        b_milli[i] = 0; b_last[i] = 0; b_cap[i] = 0; b_valid[i] = 0;
      end
      errors = 0; grants = 0; denials = 0; releases = 0;
      foreach (cause_seen[i]) cause_seen[i] = 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void set_limit(reg_idx_t r, int unsigned v);
      lim[int'(r)] = v & 16'hFFFF;
    endfunction

    function int unsigned up(int unsigned v);
      return (v < CNT_TOP) ? v + 1 : v;
    endfunction

    function int unsigned down(int unsigned v);
      return (v > 0) ? v - 1 : 0;
    endfunction

    function bit take_token(int i, int unsigned rate, longint unsigned now);
      longint unsigned el, t, cap;
      if (rate == 0) return 1'b1;
      if (!b_valid[i] || b_cap[i] != rate) begin
        b_cap[i] = rate; b_milli[i] = rate * 1000; b_last[i] = now; b_valid[i] = 1'b1;
      end else if (now > b_last[i]) begin
        el = now - b_last[i];
        if (el > 1000) el = 1000;
        t   = b_milli[i] + el * rate;
        cap = b_cap[i] * 1000;
        b_milli[i] = (t > cap) ? cap : t;
        b_last[i]  = now;
      end
      if (b_milli[i] < 1000) return 1'b0;
      b_milli[i] -= 1000;
      return 1'b1;
    endfunction

    function void give_token(int i);
      longint unsigned t, cap;
      if (b_cap[i] == 0) return;
      t   = b_milli[i] + 1000;
      cap = b_cap[i] * 1000;
      b_milli[i] = (t > cap) ? cap : t;
    endfunction

    // An accepted request: work out its response and queue it.
    function void note_request(op_t op, int unsigned ep, longint unsigned now, bit held);
      verdict_t v;
      bit gcount, gtok;
      cause_t c;
      v.granted = 1'b1; v.cause = CAUSE_NONE; v.taken = 1'b0;
      c = CAUSE_NONE;
      if (op == OP_RELEASE) begin
        s_act = down(s_act);
        e_act[ep] = down(e_act[ep]);
        if (held) g_act = down(g_act);
        releases++;
        awaited.push_back(v);
        return;
      end
      gcount = lim[int'(REG_GLOBAL_CONC)] > 0;
      if (gcount && g_act >= lim[int'(REG_GLOBAL_CONC)]) begin
        c = CAUSE_GLOBAL_CONC;
      end else begin
        if (gcount) g_act = up(g_act);
        if (lim[int'(REG_SERVICE_CONC)] > 0 && s_act >= lim[int'(REG_SERVICE_CONC)])
          c = CAUSE_SERVICE_CONC;
        else if (lim[int'(REG_ENDPOINT_CONC)] > 0 && e_act[ep] >= lim[int'(REG_ENDPOINT_CONC)])
          c = CAUSE_ENDPOINT_CONC;
        if (c != CAUSE_NONE) begin
          if (gcount) g_act = down(g_act);
        end else begin
          gtok = 1'b0;
          s_act = up(s_act);
          e_act[ep] = up(e_act[ep]);
          if (lim[int'(REG_GLOBAL_RATE)] > 0) begin
            if (!take_token(0, lim[int'(REG_GLOBAL_RATE)], now)) c = CAUSE_GLOBAL_RATE;
            else gtok = 1'b1;
          end
          if (c == CAUSE_NONE && !take_token(1, lim[int'(REG_SERVICE_RATE)], now)) begin
            c = CAUSE_SERVICE_RATE;
            if (gtok) give_token(0);
          end
          if (c == CAUSE_NONE && !take_token(2 + ep, lim[int'(REG_ENDPOINT_RATE)], now)) begin
            c = CAUSE_ENDPOINT_RATE;
            give_token(1);
            if (gtok) give_token(0);
          end
          if (c != CAUSE_NONE) begin
            s_act = down(s_act);
            e_act[ep] = down(e_act[ep]);
            if (gcount) g_act = down(g_act);
          end
        end
      end
      if (c != CAUSE_NONE) begin
        v.granted = 1'b0; v.cause = c; denials++;
      end else begin
        v.taken = gcount; grants++;
        held_ep.push_back(ep); held_g.push_back(gcount);
      end
      cause_seen[int'(c)]++;
      awaited.push_back(v);
    endfunction

    function void check_response(bit granted, logic [CAUSE_W-1:0] cause, bit taken);
      verdict_t v;
      if (awaited.size() == 0) begin
        $error("response with none awaited: granted=%0d cause=%0d taken=%0d",
               granted, cause, taken);
        errors++;
        return;
      end
      v = awaited.pop_front();
      if (granted !== v.granted) begin
        $error("granted: expected %0d, actual %0d", v.granted, granted); errors++;
      end
      if (cause !== v.cause) begin
        $error("deny_cause: expected %0d, actual %0d", v.cause, cause); errors++;
      end
      if (taken !== v.taken) begin
        $error("global_taken: expected %0d, actual %0d", v.taken, taken); errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  psel, penable, pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  altb_req_if req_ch ();
  altb_rsp_if rsp_ch ();

  admission_limiter_token_bucket_unit u_dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  admission_board  board;
  int              tx_idle_pct;   // chance per cycle that the sender idles
  int              rx_stall_pct;  // chance per cycle that the receiver stalls
  int              hold_asks;     // raised by the stimulus to ask for a long hold-off
  int              hold_done;
  int              hold_left;
  int              quiet_cycles;
  longint unsigned clock_ms;      // running time base for now_ms

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  initial begin
    board          = new();
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    req_ch.valid   = 1'b0;
    req_ch.operation      = 1'b0;
    req_ch.endpoint_index = '0;
    req_ch.now_ms         = '0;
    req_ch.global_held    = 1'b0;
    rsp_ch.ready   = 1'b0;
    tx_idle_pct    = 0;
    rx_stall_pct   = 0;
    hold_asks      = 0;
    hold_done      = 0;
    hold_left      = 0;
    quiet_cycles   = 0;
    clock_ms       = 0;
  end

  // Receiver: random stalls, plus a long hold-off counted here on request,
  // during which the block's stage fills and its request side stalls.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_asks != hold_done) begin
      hold_done    <= hold_asks;
      hold_left    <= HOLD_LONG;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Monitor: every accepted transaction on either channel goes to the board,
  // and the watchdog counts cycles in which nothing moves.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready)
        board.note_request(op_t'(req_ch.operation), int'(req_ch.endpoint_index),
                           longint'(req_ch.now_ms), req_ch.global_held);
      if (rsp_ch.valid && rsp_ch.ready)
        board.check_response(rsp_ch.granted, rsp_ch.deny_cause, rsp_ch.global_taken);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WDOG_MAX) begin
        $display("[admission_limiter_token_bucket_unit] ERROR");
        $finish;
      end
    end
  end

  // One register write: setup cycle, then access cycle.
  task automatic write_limit(reg_idx_t r, int unsigned v);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= APB_ADDR_W'(4 * int'(r));
    pwdata  <= APB_DATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.set_limit(r, v);
  endtask

  // Wait for every awaited response, then let the pipeline drain.
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limits(int unsigned gc, int unsigned sc, int unsigned ec,
                            int unsigned gr, int unsigned sr, int unsigned er);
    drain();
    write_limit(REG_GLOBAL_CONC, gc);
    write_limit(REG_SERVICE_CONC, sc);
    write_limit(REG_ENDPOINT_CONC, ec);
    write_limit(REG_GLOBAL_RATE, gr);
    write_limit(REG_SERVICE_RATE, sr);
    write_limit(REG_ENDPOINT_RATE, er);
  endtask

  // Offer one request and hold it until it is accepted; then perhaps idle.
  task automatic send_request(op_t op, int unsigned ep, longint unsigned now, bit held);
    req_ch.valid          <= 1'b1;
    req_ch.operation      <= op;
    req_ch.endpoint_index <= EP_IDX_W'(ep);
    req_ch.now_ms         <= TIME_W'(now);
    req_ch.global_held    <= held;
    do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
    while ($urandom_range(99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // A random request: mostly acquires and well-formed releases of granted
  // slots, with some stray releases; time mostly creeps forward.
  task automatic random_request();
    int unsigned pick, ep, k;
    bit          held;
    pick = $urandom_range(99);
    if (pick < 4)
      clock_ms = {$urandom, $urandom} & 48'hFFFF_FFFF_FFFF;
    else if (pick < 8 && clock_ms > 50)
      clock_ms = clock_ms - $urandom_range(50);
    else if (pick < 12)
      clock_ms = clock_ms + $urandom_range(3000);
    else
      clock_ms = clock_ms + $urandom_range(150);
    clock_ms &= 48'hFFFF_FFFF_FFFF;
    pick = $urandom_range(99);
    if (pick < 35 && board.held_ep.size() > 0) begin
      k    = $urandom_range(board.held_ep.size() - 1);
      ep   = board.held_ep[k];
      held = board.held_g[k];
      board.held_ep.delete(k);
      board.held_g.delete(k);
      send_request(OP_RELEASE, ep, {$urandom, $urandom}, held);
    end else if (pick < 42) begin
      send_request(OP_RELEASE, $urandom_range(EP_N - 1), clock_ms, 1'($urandom_range(1)));
    end else begin
      // A few endpoints take most of the traffic so that their limits bite.
      ep = ($urandom_range(3) != 0) ? $urandom_range(3) : $urandom_range(EP_N - 1);
      send_request(OP_ACQUIRE, ep, clock_ms, 1'($urandom_range(1)));
    end
  endtask

  function automatic int unsigned random_limit();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 25) return 0;
    if (p < 32) return 65535;
    if (p < 85) return $urandom_range(1, 4);
    return $urandom_range(5, 40);
  endfunction

  initial begin
    int phase, n;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. All limits at zero: everything is admitted.
    send_request(OP_ACQUIRE, 63, 48'hFFFF_FFFF_FFFF, 1'b1);
    send_request(OP_ACQUIRE, 0, 0, 1'b0);
    send_request(OP_RELEASE, 63, 48'hFFFF_FFFF_FFFF, 1'b1);
    send_request(OP_RELEASE, 0, 0, 1'b0);
    send_request(OP_RELEASE, 5, 48'hAAAA_AAAA_AAAA, 1'b1);   // floors at zero

    // Tight limits: each concurrency check and each bucket in turn.
    set_limits(2, 3, 1, 2, 3, 1);
    send_request(OP_ACQUIRE, 1, 100, 1'b0);
    send_request(OP_ACQUIRE, 1, 100, 1'b0);                   // endpoint concurrency
    send_request(OP_ACQUIRE, 2, 100, 1'b0);                   // endpoint bucket reload
    send_request(OP_ACQUIRE, 3, 100, 1'b0);                   // global concurrency
    send_request(OP_RELEASE, 1, 100, 1'b1);
    send_request(OP_RELEASE, 2, 100, 1'b1);
    send_request(OP_ACQUIRE, 4, 100, 1'b0);                   // global tokens run out
    send_request(OP_ACQUIRE, 4, 50, 1'b0);                    // time going backwards
    send_request(OP_RELEASE, 4, 0, 1'b1);
    send_request(OP_ACQUIRE, 4, 5000, 1'b0);                  // long idle refills
    send_request(OP_ACQUIRE, 4, 5000, 1'b0);                  // endpoint concurrency

    set_limits(0, 1, 0, 0, 65535, 0);
    send_request(OP_ACQUIRE, 7, 10, 1'b0);
    send_request(OP_ACQUIRE, 8, 10, 1'b0);                    // service concurrency
    send_request(OP_RELEASE, 7, 10, 1'b0);
    set_limits(0, 0, 0, 65535, 1, 0);
    send_request(OP_ACQUIRE, 9, 20, 1'b0);
    send_request(OP_ACQUIRE, 9, 20, 1'b0);                    // service rate, global returned
    // Service rate off, but its bucket still holds a capacity for the return.
    set_limits(65535, 65535, 65535, 65535, 0, 1);
    send_request(OP_ACQUIRE, 10, 30, 1'b0);
    send_request(OP_ACQUIRE, 10, 30, 1'b0);

    // Random phases, cycling through the idling patterns.
    for (phase = 0; phase < 8; phase++) begin
      if (phase == 7) set_limits(65535, 65535, 65535, 65535, 65535, 65535);
      else if (phase == 6) set_limits(0, 0, 0, 0, 0, 0);
      else set_limits(random_limit(), random_limit(), random_limit(),
                      random_limit(), random_limit(), random_limit());
      case (phase % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 81; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 81; end
        default: begin tx_idle_pct = 20; rx_stall_pct = 20; end
      endcase
      for (n = 0; n < 54; n++) begin
        if (phase == 0 && n == 10) hold_asks = hold_asks + 1;
        // Sender pause until everything owed has come back.
        if (phase == 3 && n == 27) begin
          req_ch.valid <= 1'b0;
          @(posedge clk);
          while (board.pending() != 0) @(posedge clk);
        end
        random_request();
      end
    end

    drain();
    repeat (10) @(posedge clk);
    $display("Covered %0d grants, %0d denials and %0d releases over thirteen limit settings.",
             board.grants, board.denials, board.releases);
    $display("Denials by cause: %0d %0d %0d %0d %0d %0d.", board.cause_seen[1],
             board.cause_seen[2], board.cause_seen[3], board.cause_seen[4],
             board.cause_seen[5], board.cause_seen[6]);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("[admission_limiter_token_bucket_unit] OK");
    end else begin
      $display("[admission_limiter_token_bucket_unit] ERROR");
    end
    $finish;
  end

endmodule
